>>> hdl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// shared types and constants of the single-wire sensor reader
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgLowPulse   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHighPulse  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleDly  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBytesToRd  = 2'd3;

  // line drive codes
  localparam logic [1:0] LineRelease   = 2'd0;
  localparam logic [1:0] LineDriveHigh = 2'd1;
  localparam logic [1:0] LineDriveLow  = 2'd2;

  typedef struct packed {
    logic [15:0] low_pulse_ticks;
    logic [7:0]  high_pulse_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [3:0]  bytes_to_read;
  } cfg_t;

  typedef struct packed {
    logic                   busy_res;
    logic                   no_response;
    logic                   last_byte;
    logic [BitsPerByte-1:0] byte_value;
    logic                   byte_valid;
    logic [1:0]             line_mode;
  } result_t;

endpackage

>>> hdl/swsr_core.sv
// ----------------------------------------------------------------------------
// swsr_core
// protocol sequencer: state registers and the per-tick next-state logic
// ----------------------------------------------------------------------------
module swsr_core import swsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    start_i,
  input  logic    line_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhLow      = 4'd1;
  localparam logic [3:0] PhHigh     = 4'd2;
  localparam logic [3:0] PhCheck    = 4'd3;
  localparam logic [3:0] PhWaitResp = 4'd4;
  localparam logic [3:0] PhHighEnd  = 4'd5;
  localparam logic [3:0] PhLowEnd   = 4'd6;
  localparam logic [3:0] PhDelay    = 4'd7;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [2:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  done_q, done_d;

  logic [15:0] limit;
  logic [16:0] tick_inc;
  logic        timer_done;
  logic [7:0]  shift_set;
  logic [3:0]  done_inc;
  logic [3:0]  target;

  always_comb begin
    case (phase_q)
      PhLow:   limit = cfg_i.low_pulse_ticks;
      PhHigh:  limit = {8'd0, cfg_i.high_pulse_ticks};
      default: limit = {8'd0, cfg_i.sample_delay_ticks};
    endcase
  end

  assign tick_inc   = {1'b0, tick_q} + 17'd1;
  assign timer_done = tick_inc >= {1'b0, limit};
  assign shift_set  = line_i ? (shift_q | (8'h80 >> bit_idx_q)) : shift_q;
  assign done_inc   = done_q + 4'd1;
  assign target     = (cfg_i.bytes_to_read == 4'd0) ? 4'd1 : cfg_i.bytes_to_read;

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    done_d    = done_q;
    res_o.byte_valid  = 1'b0;
    res_o.byte_value  = '0;
    res_o.last_byte   = 1'b0;
    res_o.no_response = 1'b0;

    case (phase_q)
      PhIdle: begin
        if (start_i) begin
          phase_d = PhLow;
          tick_d  = '0;
        end
      end
      PhLow, PhHigh: begin
        tick_d = timer_done ? 16'd0 : tick_inc[15:0];
        if (timer_done) begin
          phase_d = (phase_q == PhLow) ? PhHigh : PhCheck;
        end
      end
      PhCheck: begin
        if (!line_i) begin
          phase_d   = PhWaitResp;
          bit_idx_d = '0;
          shift_d   = '0;
          done_d    = '0;
        end else begin
          res_o.no_response = 1'b1;
          phase_d           = PhIdle;
        end
      end
      PhWaitResp: begin
        if (line_i) begin
          phase_d = PhHighEnd;
        end
      end
      PhHighEnd: begin
        if (!line_i) begin
          phase_d = PhLowEnd;
        end
      end
      PhLowEnd: begin
        if (line_i) begin
          phase_d = PhDelay;
          tick_d  = '0;
        end
      end
      PhDelay: begin
        tick_d = timer_done ? 16'd0 : tick_inc[15:0];
        if (timer_done) begin
          if (bit_idx_q == 3'(BitsPerByte - 1)) begin
            res_o.byte_valid = 1'b1;
            res_o.byte_value = shift_set;
            done_d           = done_inc;
            if (done_inc >= target) begin
              res_o.last_byte = 1'b1;
              phase_d         = PhIdle;
            end else begin
              phase_d = PhHighEnd;
            end
            bit_idx_d = '0;
            shift_d   = '0;
          end else begin
            shift_d   = shift_set;
            bit_idx_d = bit_idx_q + 3'd1;
            phase_d   = PhHighEnd;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    case (phase_d)
      PhLow:   res_o.line_mode = LineDriveLow;
      PhHigh:  res_o.line_mode = LineDriveHigh;
      default: res_o.line_mode = LineRelease;
    endcase
    res_o.busy_res = phase_d != PhIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      tick_q    <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      done_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      done_q    <= done_d;
    end
  end

endmodule

>>> hdl/swsr_out.sv
// ----------------------------------------------------------------------------
// swsr_out
// result register towards the output stream
// ----------------------------------------------------------------------------
module swsr_out import swsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     res_i,
  output logic        ready_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = res_q.last_byte;
  assign m_axis_tdata  = {3'd0, res_q.busy_res, res_q.no_response, res_q.byte_value,
                          res_q.byte_valid, res_q.line_mode};

endmodule

>>> hdl/single_wire_sensor_reader_top.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_top
// host side of a single-wire humidity sensor link
// ----------------------------------------------------------------------------
// Each input word is one microsecond tick carrying the start request and the
// sampled data line level; each tick gives exactly one registered result word,
// and a new tick is taken in every cycle while the result register is free or
// being drained. The sequencer drives the line low, then high, checks the
// sensor response once, then reads bytes MSB first. The user must write the
// configuration through the cfg channel only while idle; it is not enforced.
module single_wire_sensor_reader_top import swsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // start_request, line_level, zero padding
  input  logic [7:0]          s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // line_mode[1:0], byte_valid, byte_value[7:0], no_response, busy_res, padding
  output logic [15:0]         m_axis_tdata_o,
  // last_byte
  output logic                m_axis_tlast_o
);

  cfg_t    cfg_q;
  result_t res;
  logic    accept;
  logic    out_ready;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = out_ready;
  assign accept          = s_axis_tvalid_i && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_pulse_ticks    <= 16'd20000;
      cfg_q.high_pulse_ticks   <= 8'd30;
      cfg_q.sample_delay_ticks <= 8'd35;
      cfg_q.bytes_to_read      <= 4'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLowPulse:  cfg_q.low_pulse_ticks    <= cfg_data_i;
        CfgHighPulse: cfg_q.high_pulse_ticks   <= cfg_data_i[7:0];
        CfgSampleDly: cfg_q.sample_delay_ticks <= cfg_data_i[7:0];
        CfgBytesToRd: cfg_q.bytes_to_read      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  swsr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .start_i (s_axis_tdata_i[0]),
    .line_i  (s_axis_tdata_i[1]),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  swsr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o),
    .m_axis_tlast  (m_axis_tlast_o)
  );

endmodule
